// ===== sv/ehpp_pkg.sv =====
// ----------------------------------------------------------------------------
// ehpp_pkg
// Shared constants, kind codes and the command type between the framing front
// end and the row walker of the headset packet parser.
// ----------------------------------------------------------------------------
package ehpp_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'hAA;
	localparam logic [7:0] MAX_LEN   = 8'd170;

	localparam logic [7:0] CODE_QUALITY   = 8'h02;
	localparam logic [7:0] CODE_ATTENTION = 8'h04;
	localparam logic [7:0] CODE_MEDITATION = 8'h05;
	localparam logic [7:0] CODE_RAW       = 8'h80;
	localparam logic [7:0] CODE_BANDS     = 8'h83;

	localparam int NUM_KINDS = 12;
	localparam int NUM_BANDS = 8;
	localparam int KIND_W    = 4;
	localparam logic [KIND_W-1:0] KIND_QUALITY   = 4'd0;
	localparam logic [KIND_W-1:0] KIND_ATTENTION = 4'd1;
	localparam logic [KIND_W-1:0] KIND_MEDITATION = 4'd2;
	localparam logic [KIND_W-1:0] KIND_RAW       = 4'd3;
	localparam logic [KIND_W-1:0] KIND_BAND0     = 4'd4;
	localparam logic [KIND_W-1:0] KIND_LAST      = 4'd11;

	// Walk position: length byte below 171 plus a row length up to 255.
	localparam int POS_W = 10;

	localparam int DEF_PAYLOAD_DEPTH = 256;
	localparam int DEF_BAND_BYTES    = 3;

	// go = 0: store data at idx; go = 1: checksum good, walk data bytes.
	typedef struct packed {
		logic       go;
		logic [7:0] data;
		logic [7:0] idx;
	} cmd_t;

endpackage

// ===== sv/ehpp_front.sv =====
// ----------------------------------------------------------------------------
// ehpp_front
// Framing state machine: hunts sync bytes, checks the length, sums the
// payload and pushes store and walk commands into the command queue.
// ----------------------------------------------------------------------------
module ehpp_front import ehpp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	localparam logic [2:0] F_SYNC1 = 3'd0;
	localparam logic [2:0] F_SYNC2 = 3'd1;
	localparam logic [2:0] F_LEN   = 3'd2;
	localparam logic [2:0] F_PAY   = 3'd3;
	localparam logic [2:0] F_CSUM  = 3'd4;

	logic [2:0] st_q;
	logic [7:0] len_q;
	logic [7:0] cnt_q;
	logic [7:0] sum_q;
	logic       accept;
	logic       csum_ok;
	logic [7:0] cnt_nx;

	assign rx_ready = !q_full;
	assign accept   = rx_valid && rx_ready;
	assign csum_ok  = (rx_byte == ~sum_q);
	assign cnt_nx   = cnt_q + 8'd1;

	always_comb begin
		q_push      = 1'b0;
		q_cmd.go    = 1'b0;
		q_cmd.data  = rx_byte;
		q_cmd.idx   = cnt_q;
		if (accept && st_q == F_PAY) begin
			q_push = 1'b1;
		end else if (accept && st_q == F_CSUM && csum_ok) begin
			q_push     = 1'b1;
			q_cmd.go   = 1'b1;
			q_cmd.data = len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= F_SYNC1;
			len_q <= 8'd0;
			cnt_q <= 8'd0;
			sum_q <= 8'd0;
		end else if (accept) begin
			unique case (st_q)
				F_SYNC2: begin
					st_q <= (rx_byte == SYNC_BYTE) ? F_LEN : F_SYNC1;
				end
				F_LEN: begin
					// extra sync bytes before the length are skipped
					if (rx_byte != SYNC_BYTE) begin
						if (rx_byte > MAX_LEN) begin
							st_q <= F_SYNC1;
						end else begin
							len_q <= rx_byte;
							cnt_q <= 8'd0;
							sum_q <= 8'd0;
							st_q  <= (rx_byte == 8'd0) ? F_CSUM : F_PAY;
						end
					end
				end
				F_PAY: begin
					sum_q <= sum_q + rx_byte;
					cnt_q <= cnt_nx;
					if (cnt_nx >= len_q) begin
						st_q <= F_CSUM;
					end
				end
				F_CSUM: begin
					st_q <= F_SYNC1;
				end
				default: begin
					st_q <= (rx_byte == SYNC_BYTE) ? F_SYNC2 : F_SYNC1;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_go_from_csum: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_cmd.go |-> st_q == F_CSUM)
		else $error("walk command pushed outside checksum state");
`endif

endmodule

// ===== sv/ehpp_queue.sv =====
// ----------------------------------------------------------------------------
// ehpp_queue
// Two-entry command queue between the framing front end and the row walker.
// ----------------------------------------------------------------------------
module ehpp_queue import ehpp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	localparam int QDEPTH = 2;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	cmd_t             ent_q [QDEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_cmd = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command queue underflow");
`endif

endmodule

// ===== sv/ehpp_back.sv =====
// ----------------------------------------------------------------------------
// ehpp_back
// Payload store and row walker: writes queued payload bytes into the store,
// walks the rows of a good packet and emits each updated kind once.
// ----------------------------------------------------------------------------
module ehpp_back import ehpp_pkg::*; #(
	parameter int PAYLOAD_DEPTH = DEF_PAYLOAD_DEPTH,
	parameter int BAND_BYTES    = DEF_BAND_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  cmd_t              q_cmd,
	output logic              q_pop,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [KIND_W-1:0] kind,
	output logic [31:0]       value,
	output logic              last
);

	localparam int AW     = $clog2(PAYLOAD_DEPTH);
	localparam int JW     = (BAND_BYTES > 1) ? $clog2(BAND_BYTES) : 1;
	localparam logic [7:0] BAND_TOTAL = 8'(NUM_BANDS * BAND_BYTES);

	localparam logic [2:0] B_IDLE   = 3'd0;
	localparam logic [2:0] B_CODE   = 3'd1;
	localparam logic [2:0] B_SINGLE = 3'd2;
	localparam logic [2:0] B_RLEN   = 3'd3;
	localparam logic [2:0] B_RAW    = 3'd4;
	localparam logic [2:0] B_BLEN   = 3'd5;
	localparam logic [2:0] B_BAND   = 3'd6;
	localparam logic [2:0] B_EMIT   = 3'd7;

	logic [7:0]           mem [PAYLOAD_DEPTH];
	logic [7:0]           rdata_q;
	logic                 inr_q;

	logic [2:0]           st_q;
	logic                 ph_q;
	logic [7:0]           len_q;
	logic [POS_W-1:0]     p_q;
	logic [7:0]           r_q;
	logic [2:0]           b_q;
	logic [JW-1:0]        j_q;
	logic [KIND_W-1:0]    kd_q;
	logic [KIND_W-1:0]    k_q;
	logic [31:0]          acc_q;
	logic [NUM_KINDS-1:0] seen_q;
	logic [31:0]          val_q [NUM_KINDS];

	logic                 res_valid_q;
	logic [KIND_W-1:0]    kind_q;
	logic [31:0]          value_q;
	logic                 last_q;

	logic [7:0]           byte_d;
	logic [31:0]          raw_nx;
	logic [31:0]          band_nx;
	logic                 band_end;
	logic [KIND_W-1:0]    band_kind;
	logic                 val_we;
	logic [KIND_W-1:0]    val_wa;
	logic [31:0]          val_wd;
	logic                 slot_free;
	logic [NUM_KINDS-1:0] seen_hi;

	assign q_pop     = (st_q == B_IDLE) && !q_empty;
	assign byte_d    = inr_q ? rdata_q : 8'h00;
	assign raw_nx    = {acc_q[23:0], byte_d};
	assign band_nx   = (j_q == '0) ? {24'd0, byte_d} : {acc_q[23:0], byte_d};
	assign band_end  = (j_q == JW'(BAND_BYTES - 1));
	assign band_kind = KIND_BAND0 + {1'b0, b_q};
	assign slot_free = !res_valid_q || res_ready;
	assign seen_hi   = seen_q >> k_q;

	assign res_valid = res_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign last      = last_q;

	// Store writes from the queue; one read port follows the walk position.
	always_ff @(posedge clk) begin
		if (q_pop && !q_cmd.go) begin
			mem[q_cmd.idx[AW-1:0]] <= q_cmd.data;
		end
		rdata_q <= mem[p_q[AW-1:0]];
		inr_q   <= (p_q < {{(POS_W-8){1'b0}}, len_q});
	end

	always_comb begin
		val_we = 1'b0;
		val_wa = kd_q;
		val_wd = {24'd0, byte_d};
		if (ph_q) begin
			case (st_q)
				B_SINGLE: begin
					val_we = 1'b1;
				end
				B_RLEN: begin
					val_we = 1'b1;
					val_wa = KIND_RAW;
					val_wd = 32'd0;
				end
				B_RAW: begin
					val_we = 1'b1;
					val_wa = KIND_RAW;
					val_wd = raw_nx;
				end
				B_BAND: begin
					val_we = band_end;
					val_wa = band_kind;
					val_wd = band_nx;
				end
				default: begin
					val_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_q[val_wa] <= val_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			ph_q        <= 1'b0;
			len_q       <= 8'd0;
			p_q         <= '0;
			r_q         <= 8'd0;
			b_q         <= 3'd0;
			j_q         <= '0;
			kd_q        <= KIND_QUALITY;
			k_q         <= KIND_QUALITY;
			acc_q       <= 32'd0;
			seen_q      <= '0;
			res_valid_q <= 1'b0;
			kind_q      <= KIND_QUALITY;
			value_q     <= 32'd0;
			last_q      <= 1'b0;
		end else begin
			if (res_ready && !(st_q == B_EMIT && seen_q[k_q])) begin
				res_valid_q <= 1'b0;
			end
			unique case (st_q)
				B_IDLE: begin
					if (q_pop && q_cmd.go) begin
						len_q  <= q_cmd.data;
						p_q    <= '0;
						ph_q   <= 1'b0;
						seen_q <= '0;
						st_q   <= B_CODE;
					end
				end
				B_EMIT: begin
					if (!seen_q[k_q] || slot_free) begin
						if (seen_q[k_q]) begin
							res_valid_q <= 1'b1;
							kind_q      <= k_q;
							value_q     <= val_q[k_q];
							last_q      <= (seen_hi == NUM_KINDS'(1));
						end
						k_q <= k_q + KIND_W'(1);
						if (k_q == KIND_LAST) begin
							st_q <= B_IDLE;
						end
					end
				end
				default: begin
					// even phase: read at p_q; odd phase: act on the byte
					if (!ph_q) begin
						if (st_q == B_CODE && p_q >= {{(POS_W-8){1'b0}}, len_q}) begin
							k_q  <= KIND_QUALITY;
							st_q <= B_EMIT;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						case (st_q)
							B_CODE: begin
								p_q <= p_q + POS_W'(1);
								if (byte_d == CODE_QUALITY) begin
									kd_q <= KIND_QUALITY;
									st_q <= B_SINGLE;
								end else if (byte_d == CODE_ATTENTION) begin
									kd_q <= KIND_ATTENTION;
									st_q <= B_SINGLE;
								end else if (byte_d == CODE_MEDITATION) begin
									kd_q <= KIND_MEDITATION;
									st_q <= B_SINGLE;
								end else if (byte_d == CODE_RAW) begin
									st_q <= B_RLEN;
								end else if (byte_d == CODE_BANDS) begin
									st_q <= B_BLEN;
								end
							end
							B_SINGLE: begin
								p_q          <= p_q + POS_W'(1);
								seen_q[kd_q] <= 1'b1;
								st_q         <= B_CODE;
							end
							B_RLEN: begin
								p_q              <= p_q + POS_W'(1);
								seen_q[KIND_RAW] <= 1'b1;
								acc_q            <= 32'd0;
								r_q              <= byte_d;
								st_q             <= (byte_d == 8'd0) ? B_CODE : B_RAW;
							end
							B_RAW: begin
								p_q   <= p_q + POS_W'(1);
								acc_q <= raw_nx;
								r_q   <= r_q - 8'd1;
								if (r_q == 8'd1) begin
									st_q <= B_CODE;
								end
							end
							B_BLEN: begin
								// short band rows are skipped whole
								if (byte_d < BAND_TOTAL) begin
									p_q  <= p_q + POS_W'(1) + {{(POS_W-8){1'b0}}, byte_d};
									st_q <= B_CODE;
								end else begin
									p_q  <= p_q + POS_W'(1) + {{(POS_W-8){1'b0}}, byte_d}
										- {{(POS_W-8){1'b0}}, BAND_TOTAL};
									b_q  <= 3'd0;
									j_q  <= '0;
									st_q <= B_BAND;
								end
							end
							B_BAND: begin
								p_q   <= p_q + POS_W'(1);
								acc_q <= band_nx;
								if (band_end) begin
									seen_q[band_kind] <= 1'b1;
									j_q <= '0;
									if (b_q == 3'(NUM_BANDS - 1)) begin
										st_q <= B_CODE;
									end else begin
										b_q <= b_q + 3'd1;
									end
								end else begin
									j_q <= j_q + JW'(1);
								end
							end
							default: begin
								st_q <= B_IDLE;
							end
						endcase
					end
				end
			endcase
		end
	end

`ifndef SYNTH
	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(st_q) == B_EMIT)
		else $error("result raised outside emit state");
`endif

endmodule

// ===== sv/eeg_headset_packet_parser.sv =====
// ----------------------------------------------------------------------------
// eeg_headset_packet_parser
// Serial packet parser for a brainwave headset byte stream: framing front end,
// command queue and row walker with the payload store.
// ----------------------------------------------------------------------------
// Throughput: one byte a cycle while the two-entry command queue has room.
// The walker drains one payload byte a cycle while idle; after a good checksum it
// walks the rows with a read phase and an act phase per position (skipped band
// bytes are jumped over, a raw row past the end is walked out), then detects the
// end and steps through all 12 kinds, one a cycle while the result slot is free.
// Reset: asynchronous, active low; hunts the first sync byte, queue empty.
module eeg_headset_packet_parser import ehpp_pkg::*; #(
	parameter int PAYLOAD_DEPTH = DEF_PAYLOAD_DEPTH,
	parameter int BAND_BYTES    = DEF_BAND_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_ready,
	input  logic [7:0]        rx_byte,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [KIND_W-1:0] kind,
	output logic [31:0]       value,
	output logic              last
);

	logic q_push;
	cmd_t q_cmd_in;
	logic q_full;
	logic q_pop;
	cmd_t q_cmd_out;
	logic q_empty;

	ehpp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd_in)
	);

	ehpp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd_in),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (q_cmd_out),
		.empty    (q_empty)
	);

	ehpp_back #(
		.PAYLOAD_DEPTH (PAYLOAD_DEPTH),
		.BAND_BYTES    (BAND_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (q_cmd_out),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.kind      (kind),
		.value     (value),
		.last      (last)
	);

endmodule

// ===== sim/ehpp_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// ehpp_tb_pkg
// Scoreboard for the headset packet parser: tracks framing of the byte stream,
// decodes the rows of every frame with a good checksum and checks the results.
// ----------------------------------------------------------------------------
package ehpp_tb_pkg;
	import ehpp_pkg::*;

	typedef enum logic [2:0] {
		HUNT_SYNC1,
		HUNT_SYNC2,
		GET_LEN,
		GET_PAYLOAD,
		GET_CSUM
	} frame_st_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [31:0]       value;
		logic              last;
	} reading_t;

	typedef logic [7:0] byte_q_t[$];

	localparam int TB_BAND_BYTES = DEF_BAND_BYTES;
	localparam int TB_DEPTH      = DEF_PAYLOAD_DEPTH;
	localparam int BAND_ROW_MIN  = NUM_BANDS * TB_BAND_BYTES;

	class packet_scoreboard;
		frame_st_t  st;
		logic [7:0] plen;
		logic [7:0] count;
		logic [7:0] csum_acc;
		logic [7:0] store [TB_DEPTH];
		reading_t   readings_due[$];
		int         mismatches;
		int         readings_seen;
		int         good_frames;

		function new();
			st            = HUNT_SYNC1;
			plen          = '0;
			count         = '0;
			csum_acc      = '0;
			mismatches    = 0;
			readings_seen = 0;
			good_frames   = 0;
		endfunction

		// bytes past the declared length read as zero
		function logic [7:0] at(int pos);
			if (pos < int'(plen) && pos < TB_DEPTH)
				return store[pos];
			return 8'h00;
		endfunction

		function logic [31:0] be_word(int start, int nbytes);
			logic [31:0] v;
			v = '0;
			for (int j = 0; j < nbytes; j++)
				v = {v[23:0], at(start + j)};
			return v;
		endfunction

		function void decode_rows();
			bit          seen [NUM_KINDS];
			logic [31:0] val [NUM_KINDS];
			logic [7:0]  code;
			int          i, vl, s, kd, lastk;
			reading_t    r;
			for (int k = 0; k < NUM_KINDS; k++) begin
				seen[k] = 1'b0;
				val[k]  = '0;
			end
			i = 0;
			while (i < int'(plen)) begin
				code = at(i);
				if (code == CODE_QUALITY || code == CODE_ATTENTION ||
						code == CODE_MEDITATION) begin
					kd = (code == CODE_QUALITY) ? int'(KIND_QUALITY) :
						(code == CODE_ATTENTION) ? int'(KIND_ATTENTION) :
						int'(KIND_MEDITATION);
					i++;
					seen[kd] = 1'b1;
					val[kd]  = {24'h0, at(i)};
				end else if (code == CODE_RAW) begin
					i++;
					vl = at(i);
					seen[KIND_RAW] = 1'b1;
					val[KIND_RAW]  = be_word(i + 1, vl);
					i += vl;
				end else if (code == CODE_BANDS) begin
					i++;
					vl = at(i);
					// short band rows are skipped whole
					if (vl >= BAND_ROW_MIN) begin
						s = i + vl + 1 - BAND_ROW_MIN;
						for (int b = 0; b < NUM_BANDS; b++) begin
							seen[int'(KIND_BAND0) + b] = 1'b1;
							val[int'(KIND_BAND0) + b]  =
								be_word(s + b * TB_BAND_BYTES, TB_BAND_BYTES);
						end
					end
					i += vl;
				end
				i++;
			end
			lastk = -1;
			for (int k = 0; k < NUM_KINDS; k++)
				if (seen[k])
					lastk = k;
			for (int k = 0; k < NUM_KINDS; k++) begin
				if (seen[k]) begin
					r.kind  = k[KIND_W-1:0];
					r.value = val[k];
					r.last  = (k == lastk);
					readings_due.push_back(r);
				end
			end
		endfunction

		function void note_byte(logic [7:0] b);
			case (st)
			HUNT_SYNC2: begin
				st = (b == SYNC_BYTE) ? GET_LEN : HUNT_SYNC1;
			end
			GET_LEN: begin
				if (b != SYNC_BYTE) begin
					if (b > MAX_LEN) begin
						st = HUNT_SYNC1;
					end else begin
						plen     = b;
						count    = '0;
						csum_acc = '0;
						st       = (b == 8'h00) ? GET_CSUM : GET_PAYLOAD;
					end
				end
			end
			GET_PAYLOAD: begin
				store[count] = b;
				csum_acc     = csum_acc + b;
				count        = count + 8'd1;
				if (count >= plen)
					st = GET_CSUM;
			end
			GET_CSUM: begin
				if (b == ~csum_acc) begin
					good_frames++;
					decode_rows();
				end
				st = HUNT_SYNC1;
			end
			default: begin
				st = (b == SYNC_BYTE) ? HUNT_SYNC2 : HUNT_SYNC1;
			end
			endcase
		endfunction

		function void check_result(logic [KIND_W-1:0] kind, logic [31:0] value,
				logic last);
			reading_t e;
			if (readings_due.size() == 0) begin
				$error("unexpected result: kind %0d value %h last %0d", kind, value, last);
				mismatches++;
				return;
			end
			e = readings_due.pop_front();
			readings_seen++;
			if (kind !== e.kind) begin
				$error("kind: expected %0d, actual %0d", e.kind, kind);
				mismatches++;
			end
			if (value !== e.value) begin
				$error("value: expected %h, actual %h", e.value, value);
				mismatches++;
			end
			if (last !== e.last) begin
				$error("last: expected %0d, actual %0d", e.last, last);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the headset packet parser with a byte stream of directed and random
// frames, gapped on both handshakes, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ehpp_pkg::*;
	import ehpp_tb_pkg::*;

	localparam int  RANDOM_BYTES = 420;
	localparam int  HOLD_CYCLES  = 600;
	localparam int  DRAIN_CYCLES = 600;
	localparam real LIMIT_NS     = 5_000_000.0;

	localparam logic [7:0] OPENING [25] = '{
		8'hFF,                                   // noise while hunting
		SYNC_BYTE, 8'h55,                        // second sync mismatch
		SYNC_BYTE, SYNC_BYTE, 8'hAB,             // length 171, dropped
		SYNC_BYTE, SYNC_BYTE, SYNC_BYTE, 8'h00, 8'hFF, // extra sync, empty payload
		SYNC_BYTE, SYNC_BYTE, 8'h05,             // raw code runs past the end
		CODE_QUALITY, 8'h00, CODE_ATTENTION, 8'hFF, CODE_RAW, 8'h7A,
		SYNC_BYTE, SYNC_BYTE, 8'h01, CODE_MEDITATION, 8'h00 // bad checksum
	};

	logic              clk;
	logic              arst_n;
	logic              rx_valid;
	logic              rx_ready;
	logic [7:0]        rx_byte;
	logic              res_valid;
	logic              res_ready;
	logic [KIND_W-1:0] kind;
	logic [31:0]       value;
	logic              last;

	packet_scoreboard sb = new();

	int bytes_sent  = 0;
	int frames_sent = 0;
	bit no_idle     = 1'b0;
	bit hold_req    = 1'b0;
	bit hold_done   = 1'b0;

	eeg_headset_packet_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx_byte   (rx_byte),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.kind      (kind),
		.value     (value),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (rx_valid && rx_ready)
			sb.note_byte(rx_byte);
		if (res_valid && res_ready)
			sb.check_result(kind, value, last);
	end

	function automatic int idle_gap();
		int roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// lean toward the extremes now and then
	function automatic logic [7:0] rand8();
		int roll;
		roll = $urandom_range(0, 15);
		if (roll == 0)
			return 8'h00;
		if (roll == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic byte_q_t build_rows(int target);
		byte_q_t    q;
		int         vl;
		logic [7:0] code;
		while (q.size() < target) begin
			case ($urandom_range(0, 9))
			0, 1: begin
				q.push_back(CODE_QUALITY);
				q.push_back(rand8());
			end
			2: begin
				q.push_back(CODE_ATTENTION);
				q.push_back(rand8());
			end
			3: begin
				q.push_back(CODE_MEDITATION);
				q.push_back(rand8());
			end
			4, 5: begin
				vl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 10) :
					$urandom_range(0, 4);
				q.push_back(CODE_RAW);
				q.push_back(vl[7:0]);
				repeat (vl) q.push_back(rand8());
			end
			6, 7: begin
				vl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, BAND_ROW_MIN - 1) :
					$urandom_range(BAND_ROW_MIN, BAND_ROW_MIN + 4);
				q.push_back(CODE_BANDS);
				q.push_back(vl[7:0]);
				repeat (vl) q.push_back(rand8());
			end
			default: begin
				do code = rand8();
				while (code == CODE_QUALITY || code == CODE_ATTENTION ||
					code == CODE_MEDITATION || code == CODE_RAW || code == CODE_BANDS);
				q.push_back(code);
				if ($urandom_range(0, 1))
					q.push_back(rand8());
			end
			endcase
		end
		return q;
	endfunction

	// hold valid and the byte until the transaction completes
	task automatic push_byte(input logic [7:0] b);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk);
		while (!rx_ready);
		bytes_sent++;
	endtask

	task automatic push_frame(input int target, input bit corrupt);
		byte_q_t    body;
		int         len;
		logic [7:0] sum;
		body = build_rows(target);
		len  = (body.size() > int'(MAX_LEN)) ? int'(MAX_LEN) : body.size();
		// cut the last row short sometimes
		if (len > 3 && $urandom_range(0, 6) == 0)
			len -= $urandom_range(1, 3);
		sum = '0;
		push_byte(SYNC_BYTE);
		push_byte(SYNC_BYTE);
		if ($urandom_range(0, 9) == 0)
			push_byte(SYNC_BYTE);
		push_byte(len[7:0]);
		for (int j = 0; j < len; j++) begin
			push_byte(body[j]);
			sum = sum + body[j];
		end
		push_byte(corrupt ? (~sum ^ (8'h01 << $urandom_range(0, 7))) : ~sum);
		frames_sent++;
	endtask

	initial begin : receiver
		int n;
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				n = idle_gap();
				if (n > 0) begin
					res_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				res_ready <= 1'b1;
				n = $urandom_range(1, 8);
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int  pick;
		bit  pressure_done;
		pressure_done = 1'b0;
		arst_n   = 1'b0;
		rx_valid = 1'b0;
		rx_byte  = 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING[j])
			push_byte(OPENING[j]);

		while (bytes_sent < $size(OPENING) + RANDOM_BYTES) begin
			if (!pressure_done && bytes_sent > 150) begin
				// stall the result side and keep feeding good frames
				pressure_done = 1'b1;
				no_idle  = 1'b1;
				hold_req = 1'b1;
				while (!hold_done)
					push_frame($urandom_range(4, 20), 1'b0);
				no_idle = 1'b0;
			end
			no_idle = (bytes_sent >= 260 && bytes_sent < 340);
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				push_frame($urandom_range(1, 30), 1'b0);
			end else if (pick < 80) begin
				push_frame($urandom_range(1, 20), 1'b1);
			end else if (pick < 85) begin
				push_byte(SYNC_BYTE);
				push_byte(SYNC_BYTE);
				push_byte(8'($urandom_range(int'(MAX_LEN) + 1, 255)));
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 4)) push_byte(rand8());
			end else if (pick < 95) begin
				push_byte(SYNC_BYTE);
				push_byte(8'($urandom_range(0, int'(SYNC_BYTE) - 1)));
			end else begin
				push_frame($urandom_range(120, 200), 1'b0);
			end
		end
		rx_valid <= 1'b0;
		no_idle = 1'b0;

		while (sb.readings_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d built frames plus noise; %0d frames had a good checksum.",
			bytes_sent, frames_sent, sb.good_frames);
		$display("Checked %0d results, including a long result-side stall with input backpressure.",
			sb.readings_seen);
		if (sb.mismatches == 0 && sb.readings_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== eeg_headset_packet_parser.f =====
sv/ehpp_pkg.sv
sv/ehpp_front.sv
sv/ehpp_queue.sv
sv/ehpp_back.sv
sv/eeg_headset_packet_parser.sv
sim/ehpp_tb_pkg.sv
sim/tb_top.sv
